FILE: rtl/core/fit_page_allocator_core_assert.svh
// assertion macros for the fit page allocator core
// used by the controller and the top level, no other dependencies
`ifndef FIT_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_PAGE_ALLOCATOR_CORE_ASSERT_SVH

// property holds in the same cycle as its antecedent
`define FPA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpa assertion failed");

// property holds in the cycle after its antecedent
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpa assertion failed");

`endif

FILE: rtl/core/fpa_pkg.sv
// shared constants and types of the fit page allocator core
// no dependencies
package fpa_pkg;

   localparam int PAGES_DEF   = 32;
   localparam int ID_BITS_DEF = 8;

   // request and response field widths
   localparam int OP_W     = 2;
   localparam int PID_W    = 8;
   localparam int NEED_W   = 6;
   localparam int STATUS_W = 3;
   localparam int MOVED_W  = 6;
   localparam int START_W  = 5;
   localparam int FRAG_W   = 5;

   // operation codes
   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_KILL  = 2'd1;
   localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RUNNING  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NOMEM    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PID_W-1:0]  program_id;
      logic [NEED_W-1:0] pages;
      logic              fit_mode;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MOVED_W-1:0]  pages_moved;
      logic [START_W-1:0]  start_page;
      logic [FRAG_W-1:0]   free_fragments;
   } res_type;

endpackage

FILE: rtl/core/fpa_req_if.sv
// request channel of the fit page allocator core
// depends on fpa_pkg
interface fpa_req_if;
   import fpa_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [PID_W-1:0]  program_id;
   logic [NEED_W-1:0] pages;

   modport source (output valid, output op, output program_id, output pages, input ready);
   modport sink (input valid, input op, input program_id, input pages, output ready);
endinterface

FILE: rtl/core/fpa_rsp_if.sv
// response channel of the fit page allocator core
// depends on fpa_pkg
interface fpa_rsp_if;
   import fpa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MOVED_W-1:0]  pages_moved;
   logic [START_W-1:0]  start_page;
   logic [FRAG_W-1:0]   free_fragments;

   modport source (output valid, output status, output pages_moved, output start_page,
                   output free_fragments, input ready);
   modport sink (input valid, input status, input pages_moved, input start_page,
                 input free_fragments, output ready);
endinterface

FILE: rtl/core/fpa_cell.sv
// one page cell of the owner ring: holds the owner id of one page
// no package dependencies
module fpa_cell #(
   parameter int ID_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift,
   input  logic [ID_BITS-1:0] d_in,
   output logic [ID_BITS-1:0] q
);
   logic [ID_BITS-1:0] owner_ff;
   logic [ID_BITS-1:0] owner_in;

   assign owner_in = shift ? d_in : owner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_ff <= '0;
      end else begin
         owner_ff <= owner_in;
      end
   end

   assign q = owner_ff;
endmodule

FILE: rtl/core/fpa_ctrl.sv
// sequencer and scanner at the head of the owner ring
// depends on fpa_pkg and fit_page_allocator_core_assert.svh
module fpa_ctrl #(
   parameter int PAGES   = fpa_pkg::PAGES_DEF,
   parameter int ID_BITS = fpa_pkg::ID_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_load,
   input  fpa_pkg::cmd_type   cmd,
   output logic               idle,
   input  logic [ID_BITS-1:0] head,
   output logic               shift,
   output logic [ID_BITS-1:0] wr_val,
   input  logic               out_free,
   output logic               done,
   output fpa_pkg::res_type   res
);
   import fpa_pkg::*;

`include "fit_page_allocator_core_assert.svh"

   localparam int AW = $clog2(PAGES);
   localparam int LW = $clog2(PAGES + 1);
   localparam int CW = (LW > NEED_W) ? LW : NEED_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_WRITE = 4'b0100,
      ST_POST  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      step_ff, step_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [NEED_W-1:0]  need_ff, need_in;
   logic               mode_ff, mode_in;
   logic               prev_free_ff, prev_free_in;
   logic [AW-1:0]      run_start_ff, run_start_in;
   logic [LW-1:0]      run_len_ff, run_len_in;
   logic [LW-1:0]      frag_ff, frag_in;
   logic [LW-1:0]      moved_ff, moved_in;
   logic               present_ff, present_in;
   logic               best_vld_ff, best_vld_in;
   logic [AW-1:0]      best_start_ff, best_start_in;
   logic [CW-1:0]      best_left_ff, best_left_in;
   res_type            res_ff, res_in;

   logic               free_pg, last, opening, closing, fits, take, match, in_window;
   logic [AW-1:0]      cur_start, cl_start, offset;
   logic [LW-1:0]      cur_len, cl_len, kill_cnt;
   logic [CW-1:0]      left;
   logic [ID_BITS-1:0] cmd_id;

   // run tracking on the page passing the head
   always_comb begin
      free_pg   = (head == '0);
      last      = (step_ff == AW'(PAGES - 1));
      opening   = free_pg && !prev_free_ff;
      cur_start = opening ? step_ff : run_start_ff;
      cur_len   = opening ? LW'(1) : LW'(run_len_ff + LW'(1));
      closing   = (prev_free_ff && !free_pg) || (free_pg && last);
      cl_len    = free_pg ? cur_len : run_len_ff;
      cl_start  = free_pg ? cur_start : run_start_ff;
      fits      = (CW'(cl_len) >= CW'(need_ff));
      left      = CW'(cl_len) - CW'(need_ff);
      take      = closing && fits &&
                  (!best_vld_ff || (mode_ff ? (left < best_left_ff) : (left > best_left_ff)));
      match     = (head == id_ff);
      kill_cnt  = LW'(moved_ff + LW'(match));
      offset    = step_ff - best_start_ff;
      in_window = (step_ff >= best_start_ff) && (CW'(offset) < CW'(need_ff));
      cmd_id    = ID_BITS'(cmd.program_id);
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      need_in       = need_ff;
      mode_in       = mode_ff;
      prev_free_in  = prev_free_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      frag_in       = frag_ff;
      moved_in      = moved_ff;
      present_in    = present_ff;
      best_vld_in   = best_vld_ff;
      best_start_in = best_start_ff;
      best_left_in  = best_left_ff;
      res_in        = res_ff;
      wr_val        = head;
      shift         = 1'b0;
      done          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_load) begin
               op_in         = cmd.op;
               id_in         = cmd_id;
               need_in       = cmd.pages;
               mode_in       = cmd.fit_mode;
               step_in       = '0;
               prev_free_in  = 1'b0;
               run_start_in  = '0;
               run_len_in    = '0;
               frag_in       = '0;
               moved_in      = '0;
               present_in    = 1'b0;
               best_vld_in   = 1'b0;
               best_start_in = '0;
               best_left_in  = '0;
               res_in        = '{status: STAT_INVALID, default: '0};
               if ((cmd.op == OP_ADD && cmd_id != '0 && cmd.pages != '0) ||
                   (cmd.op == OP_KILL && cmd_id != '0) || cmd.op == OP_COUNT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_POST;
               end
            end
         end
         ST_SCAN: begin
            shift        = 1'b1;
            prev_free_in = free_pg;
            run_start_in = cur_start;
            run_len_in   = free_pg ? cur_len : '0;
            frag_in      = LW'(frag_ff + LW'(opening));
            present_in   = present_ff || match;
            if (take) begin
               best_vld_in   = 1'b1;
               best_start_in = cl_start;
               best_left_in  = left;
            end
            if (op_ff == OP_KILL && match) begin
               wr_val = '0;
            end
            moved_in = kill_cnt;
            step_in  = AW'(step_ff + AW'(1));
            if (last) begin
               step_in  = '0;
               state_in = ST_POST;
               res_in   = '{status: STAT_OK, default: '0};
               case (op_ff)
                  OP_ADD: begin
                     if (present_ff || match) begin
                        res_in.status = STAT_RUNNING;
                     end else if (!(best_vld_ff || take)) begin
                        res_in.status = STAT_NOMEM;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  OP_KILL: begin
                     if (kill_cnt == '0) begin
                        res_in.status = STAT_NOTFOUND;
                     end else begin
                        res_in.pages_moved = MOVED_W'(kill_cnt);
                     end
                  end
                  default: begin
                     res_in.free_fragments = FRAG_W'(frag_ff + LW'(opening));
                  end
               endcase
            end
         end
         ST_WRITE: begin
            shift   = 1'b1;
            if (in_window) begin
               wr_val = id_ff;
            end
            step_in = AW'(step_ff + AW'(1));
            if (last) begin
               step_in  = '0;
               state_in = ST_POST;
               res_in   = '{status: STAT_OK, pages_moved: need_ff,
                            start_page: START_W'(best_start_ff), default: '0};
            end
         end
         ST_POST: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      need_ff       <= need_in;
      mode_ff       <= mode_in;
      prev_free_ff  <= prev_free_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      frag_ff       <= frag_in;
      moved_ff      <= moved_in;
      present_ff    <= present_in;
      best_vld_ff   <= best_vld_in;
      best_start_ff <= best_start_in;
      best_left_ff  <= best_left_in;
      res_ff        <= res_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign res  = res_ff;

   // outside the write pass the ring is only ever cleared, never given an owner
   `FPA_ASSERT_SAME(a_clear_only, clock, reset,
      state_ff != ST_WRITE && wr_val != head, wr_val == '0)
   // the write pass only runs once a fitting run was found
   `FPA_ASSERT_SAME(a_write_has_run, clock, reset, state_ff == ST_WRITE, best_vld_ff)
   // the ring never moves while waiting to hand over a result
   `FPA_ASSERT_SAME(a_still_in_post, clock, reset,
      state_ff == ST_POST || state_ff == ST_IDLE, !shift)
endmodule

FILE: rtl/core/fit_page_allocator_core.sv
// top level of the fit page allocator: owner ring of page cells plus sequencer
// depends on fpa_pkg, fpa_req_if, fpa_rsp_if, fpa_cell, fpa_ctrl and the assert header
//
// usage
//  - req_port carries one request: op (add, kill, count free runs), program_id, pages
//  - rsp_port returns exactly one response per request, in order
//  - csr_wr_en/csr_wr_data write fit_mode (1 best fit, 0 worst fit), only while idle
//  - page owners sit in a ring of PAGES cells that rotates one page a cycle past the
//    scanner at its head during scan and write; a full turn restores the map
// sequence
//  - add: a scan turn of the ring, then a write turn that stores the new owner;
//    an add rejected by the scan (id running, no memory) skips the write turn
//  - kill and count: a scan turn only
//  - invalid requests (id zero, zero pages, unused op) skip the scan entirely
//  - one request at a time; the next is taken once the sequencer is back in idle
// reset
//  - synchronous, active high; every page free, fit_mode back to best fit
// stall
//  - the response sits in an output register; the next request is accepted while
//    it waits, and that request's response holds in the sequencer until it is taken
module fit_page_allocator_core #(
   parameter int PAGES   = fpa_pkg::PAGES_DEF,
   parameter int ID_BITS = fpa_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data,
   fpa_req_if.sink          req_port,
   fpa_rsp_if.source        rsp_port
);
   import fpa_pkg::*;

`include "fit_page_allocator_core_assert.svh"

   // fit mode register
   logic fit_mode_ff, fit_mode_in;

   // ring of page cells, cell 0 is the head seen by the scanner
   logic [ID_BITS-1:0] owner_q [PAGES];
   logic [ID_BITS-1:0] wr_val;
   logic               shift;

   // sequencer handshake
   logic    idle, done, out_free, req_take;
   cmd_type cmd;
   res_type res;

   // response output register
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff, rsp_in;

   assign fit_mode_in = csr_wr_en ? csr_wr_data : fit_mode_ff;

   assign req_port.ready = idle;
   assign req_take       = req_port.valid && idle;
   assign cmd            = '{op: req_port.op, program_id: req_port.program_id,
                             pages: req_port.pages, fit_mode: fit_mode_ff};

   // page i takes from page i+1, the last cell takes the possibly rewritten head
   for (genvar i = 0; i < PAGES; i++) begin : g_cell
      logic [ID_BITS-1:0] d_in;
      if (i == PAGES - 1) begin : g_tail
         assign d_in = wr_val;
      end else begin : g_mid
         assign d_in = owner_q[i + 1];
      end
      fpa_cell #(
         .ID_BITS (ID_BITS)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .d_in  (d_in),
         .q     (owner_q[i])
      );
   end

   fpa_ctrl #(
      .PAGES   (PAGES),
      .ID_BITS (ID_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cmd_load (req_take),
      .cmd      (cmd),
      .idle     (idle),
      .head     (owner_q[0]),
      .shift    (shift),
      .wr_val   (wr_val),
      .out_free (out_free),
      .done     (done),
      .res      (res)
   );

   // output register may load when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         fit_mode_ff  <= fit_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.status         = rsp_ff.status;
   assign rsp_port.pages_moved    = rsp_ff.pages_moved;
   assign rsp_port.start_page     = rsp_ff.start_page;
   assign rsp_port.free_fragments = rsp_ff.free_fragments;

   // a request keeps the block busy for at least the next cycle
   `FPA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_take, !req_port.ready)
   // a finished result never overwrites a response still waiting
   `FPA_ASSERT_SAME(a_no_overwrite, clock, reset, done, !rsp_valid_ff || rsp_port.ready)
endmodule

FILE: sim/tb_fit_page_allocator_core.sv
// self-checking testbench for fit_page_allocator_core: directed and random requests
// depends on fpa_pkg, fpa_req_if, fpa_rsp_if and the core itself
// every response is checked against an owner map kept in the testbench
module tb_fit_page_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import fpa_pkg::*;

   localparam int NUM_PAGES = PAGES_DEF;
   // the one op code the core leaves unused
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // cycles without any handshake or register write before the run is abandoned
   localparam int STALL_LIMIT = 5000;
   // longest request latency, an add with scan and write turns
   localparam int ADD_LATENCY = 2 * NUM_PAGES + 1;
   localparam int MAX_PRINTED = 30;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   fpa_req_if req_bus ();
   fpa_rsp_if rsp_bus ();

   fit_page_allocator_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_port    (req_bus),
      .rsp_port    (rsp_bus)
   );

   // 2 ns period, rising edge at 1 ns
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // testbench copy of the page map and the fit mode
   logic [PID_W-1:0] owner_map [NUM_PAGES];
   logic             fit_best;

   // responses still owed by the core, oldest first
   res_type expected_responses [$];

   int error_count   = 0;
   int request_count = 0;
   int checked_count = 0;
   int mode_writes   = 0;
   int status_seen [5];

   // idle percentages for the two sides, and the long receiver hold-off
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles   = 0;

   // ------------------------------------------------------------------
   // owner map predictor
   // ------------------------------------------------------------------

   // works out the response to one request and updates the owner map
   function automatic res_type predict_response(input logic [OP_W-1:0] op,
                                                input logic [PID_W-1:0] pid,
                                                input logic [NEED_W-1:0] need);
      res_type rsp;
      int      best_start;
      int      best_left;
      int      i;
      int      run_start;
      int      run_len;
      int      reclaimed;
      bit      owned;
      bit      take;
      bit      prev_free;

      rsp        = '0;
      rsp.status = STAT_INVALID;
      case (op)
         OP_ADD: begin
            owned = 1'b0;
            for (i = 0; i < NUM_PAGES; i++)
               if (owner_map[i] == pid)
                  owned = 1'b1;
            if (pid == '0 || need == '0) begin
               rsp.status = STAT_INVALID;
            end else if (owned) begin
               rsp.status = STAT_RUNNING;
            end else begin
               // walk the free runs, keep the one whose leftover suits the mode
               best_start = -1;
               best_left  = 0;
               i = 0;
               while (i < NUM_PAGES) begin
                  if (owner_map[i] != '0) begin
                     i++;
                  end else begin
                     run_start = i;
                     while (i < NUM_PAGES && owner_map[i] == '0)
                        i++;
                     run_len = i - run_start;
                     if (run_len >= need) begin
                        if (best_start < 0)
                           take = 1'b1;
                        else if (fit_best)
                           take = (run_len - need) < best_left;
                        else
                           take = (run_len - need) > best_left;
                        if (take) begin
                           best_start = run_start;
                           best_left  = run_len - need;
                        end
                     end
                  end
               end
               if (best_start < 0) begin
                  rsp.status = STAT_NOMEM;
               end else begin
                  for (i = best_start; i < best_start + need; i++)
                     owner_map[i] = pid;
                  rsp.status      = STAT_OK;
                  rsp.pages_moved = need;
                  rsp.start_page  = START_W'(best_start);
               end
            end
         end
         OP_KILL: begin
            if (pid == '0) begin
               rsp.status = STAT_INVALID;
            end else begin
               reclaimed = 0;
               for (i = 0; i < NUM_PAGES; i++)
                  if (owner_map[i] == pid) begin
                     owner_map[i] = '0;
                     reclaimed++;
                  end
               if (reclaimed == 0) begin
                  rsp.status = STAT_NOTFOUND;
               end else begin
                  rsp.status      = STAT_OK;
                  rsp.pages_moved = MOVED_W'(reclaimed);
               end
            end
         end
         OP_COUNT: begin
            rsp.status = STAT_OK;
            prev_free  = 1'b0;
            for (i = 0; i < NUM_PAGES; i++) begin
               if (owner_map[i] == '0 && !prev_free)
                  rsp.free_fragments = rsp.free_fragments + FRAG_W'(1);
               prev_free = (owner_map[i] == '0);
            end
         end
         default: rsp.status = STAT_INVALID;
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offers one request at a falling edge and waits for it to be taken;
   // valid stays high into the next request unless an idle gap is drawn
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic [PID_W-1:0] pid,
                               input logic [NEED_W-1:0] need);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.program_id <= pid;
      req_bus.pages      <= need;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      // taken at this edge: predict now, in acceptance order
      expected_responses.push_back(predict_response(op, pid, need));
      request_count++;
   endtask

   // drops valid and waits until every owed response has been seen
   task automatic wait_for_responses;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_responses.size() != 0)
         @(posedge clock);
   endtask

   // fit mode is only written while the core is idle
   task automatic set_fit_mode(input logic mode);
      wait_for_responses();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      fit_best = mode;
      mode_writes++;
   endtask

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------

   // receiver ready: random idling, or held low while a hold-off is counting down
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTED)
         $display("%t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // every response taken is compared with the oldest prediction
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response, status", rsp_bus.status, -1);
         end else begin
            want = expected_responses.pop_front();
            checked_count++;
            if (want.status <= STAT_INVALID)
               status_seen[want.status]++;
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.pages_moved !== want.pages_moved)
               report_mismatch("pages_moved", rsp_bus.pages_moved, want.pages_moved);
            if (rsp_bus.start_page !== want.start_page)
               report_mismatch("start_page", rsp_bus.start_page, want.start_page);
            if (rsp_bus.free_fragments !== want.free_fragments)
               report_mismatch("free_fragments", rsp_bus.free_fragments,
                               want.free_fragments);
         end
      end
   end

   // watchdog: any handshake or register write restarts the count
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
                   (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
                   csr_wr_en === 1'b1) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles, %0d responses owed", quiet_cycles,
                     expected_responses.size());
            $display("tb_fit_page_allocator_core NOT OK");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // field extremes and every rejection path
   task automatic test_directed;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_request(OP_COUNT, 8'd0, 6'd0);      // one run over the empty map
      send_request(OP_ADD, 8'd0, 6'd5);        // id zero is reserved
      send_request(OP_ADD, 8'd1, 6'd0);        // zero pages
      send_request(OP_ADD, 8'd255, 6'd63);     // larger than the whole memory
      send_request(OP_ADD, 8'd1, 6'd32);       // exactly fills the memory
      send_request(OP_COUNT, 8'd0, 6'd0);      // no free runs left
      send_request(OP_ADD, 8'd2, 6'd1);        // full memory
      send_request(OP_ADD, 8'd1, 6'd3);        // duplicate, checked before the fit search
      send_request(OP_KILL, 8'd0, 6'd0);       // id zero
      send_request(OP_KILL, 8'd7, 6'd0);       // id not present
      send_request(OP_KILL, 8'd1, 6'd63);      // reclaims all pages
      send_request(OP_UNUSED, 8'd170, 6'd21);  // unused op code
      send_request(OP_COUNT, 8'd255, 6'd63);   // query ignores id and size
   endtask

   // same hole pattern under both modes: holes of 4 and 6 pages, then an add of 4
   task automatic test_fit_choice;
      logic mode;
      for (int m = 0; m < 2; m++) begin
         mode = m[0];
         set_fit_mode(mode);
         send_request(OP_ADD, 8'd10, 6'd4);
         send_request(OP_ADD, 8'd11, 6'd2);
         send_request(OP_ADD, 8'd12, 6'd6);
         send_request(OP_ADD, 8'd13, 6'd20);
         send_request(OP_KILL, 8'd10, 6'd0);
         send_request(OP_KILL, 8'd12, 6'd0);
         // best fit takes the exact hole, worst fit the larger one
         send_request(OP_ADD, 8'd14, 6'd4);
         send_request(OP_KILL, 8'd11, 6'd0);
         send_request(OP_COUNT, 8'd0, 6'd0);
         send_request(OP_KILL, 8'd13, 6'd0);
         send_request(OP_KILL, 8'd14, 6'd0);
      end
   endtask

   // receiver holds off while requests keep coming, so the core backs up
   task automatic test_back_pressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      wait_for_responses();
      @(posedge clock);
      hold_cycles = 400;
      send_request(OP_ADD, 8'd40, 6'd3);
      send_request(OP_ADD, 8'd41, 6'd3);
      send_request(OP_COUNT, 8'd0, 6'd0);
      send_request(OP_KILL, 8'd40, 6'd0);
      send_request(OP_ADD, 8'd42, 6'd5);
      send_request(OP_COUNT, 8'd0, 6'd0);
      send_request(OP_KILL, 8'd41, 6'd0);
      send_request(OP_KILL, 8'd42, 6'd0);
   endtask

   // mostly a small pool of live ids so adds and kills meet each other;
   // a tenth of the ids and a few sizes span the whole field range
   task automatic run_random_phase(input int items, input int send_pct, input int recv_pct);
      logic [PID_W-1:0]  id_pool [12];
      logic [OP_W-1:0]   op;
      logic [PID_W-1:0]  pid;
      logic [NEED_W-1:0] need;
      int                pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      foreach (id_pool[j])
         id_pool[j] = PID_W'($urandom_range(1, 255));
      for (int k = 0; k < items; k++) begin
         if (k != 0 && k % 150 == 0)
            set_fit_mode(1'($urandom_range(0, 1)));
         pick = $urandom_range(99);
         if (pick < 45)
            op = OP_ADD;
         else if (pick < 78)
            op = OP_KILL;
         else if (pick < 95)
            op = OP_COUNT;
         else
            op = OP_UNUSED;
         if ($urandom_range(9) == 0)
            pid = PID_W'($urandom_range(0, 255));
         else
            pid = id_pool[$urandom_range(0, 11)];
         pick = $urandom_range(99);
         if (pick < 65)
            need = NEED_W'($urandom_range(1, 6));
         else if (pick < 85)
            need = NEED_W'($urandom_range(1, 16));
         else if (pick < 93)
            need = NEED_W'($urandom_range(17, 32));
         else
            need = NEED_W'($urandom_range(0, 63));
         send_request(op, pid, need);
      end
   endtask

   // ------------------------------------------------------------------
   // run sequence
   // ------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.op         = '0;
      req_bus.program_id = '0;
      req_bus.pages      = '0;
      rsp_bus.ready      = 1'b0;
      foreach (owner_map[i])
         owner_map[i] = '0;
      fit_best = 1'b1;
      foreach (status_seen[i])
         status_seen[i] = 0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_fit_choice();
      test_back_pressure();
      // sender rarely idles, receiver often; then the reverse; then flat out
      run_random_phase(600, 6, 50);
      run_random_phase(600, 50, 6);
      run_random_phase(600, 0, 0);

      wait_for_responses();
      // room for any stray response after the last one owed
      repeat (ADD_LATENCY + 8) @(posedge clock);
      if (expected_responses.size() != 0)
         report_mismatch("responses never returned", 0, expected_responses.size());

      $display("covered %0d requests and %0d checked responses over %0d fit mode writes",
               request_count, checked_count, mode_writes);
      $display("statuses: ok %0d, running %0d, no memory %0d, not found %0d, invalid %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4]);
      if (error_count == 0) begin
         $display("tb_fit_page_allocator_core OK");
      end else begin
         $display("tb_fit_page_allocator_core NOT OK");
      end
      $finish;
   end

endmodule
